FILE: hdl/c2s_pkg.sv
package c2s_pkg;

   // geometry of the index space
   localparam int MAX_DIMS   = 5;
   localparam int MIN_DIMS   = 3;
   localparam int IDX_W      = 32;
   localparam int GEO_W      = 16;
   localparam int DIMS_W     = 3;
   localparam int DCNT_W     = $clog2(MAX_DIMS + 1);
   localparam int CSR_IDX_W  = $clog2(MAX_DIMS + 1);
   localparam int CSR_DATA_W = 32;

   // divider pipeline shape: quotient bits resolved per stage
   localparam int STEP_BITS  = 4;
   localparam int DIV_STAGES = IDX_W / STEP_BITS;
   localparam int NUM_LANES  = 2 * MAX_DIMS;

   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [GEO_W-1:0]      geo_type;
   typedef logic [DIMS_W-1:0]     dims_type;
   typedef logic [DCNT_W-1:0]     dcnt_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   typedef idx_type [NUM_LANES-1:0] lane_idx_type;
   typedef geo_type [NUM_LANES-1:0] lane_geo_type;
   typedef geo_type [MAX_DIMS-1:0]  dim_geo_type;

   // register indexes
   localparam csr_idx_type CSR_DIMS_IN_USE = csr_idx_type'(0);
   localparam csr_idx_type CSR_GEOM_BASE   = csr_idx_type'(1);

   localparam dims_type     DIMS_RESET = dims_type'(MIN_DIMS);
   localparam csr_data_type GEOM_RESET = csr_data_type'(65537);
   localparam geo_type      GEO_ONE    = geo_type'(1);

   // partial remainder and shifting numerator/quotient word of one lane
   typedef struct packed {
      geo_type rem;
      idx_type part;
   } div_state_type;

   // STEP_BITS restoring division steps, one quotient bit each
   function automatic div_state_type div_step(div_state_type s, geo_type den);
      logic [GEO_W:0] trial;
      div_state_type  r;
      r = s;
      for (int i = 0; i < STEP_BITS; i++) begin
         trial  = {r.rem, r.part[IDX_W-1]};
         r.part = {r.part[IDX_W-2:0], 1'b0};
         if (trial >= {1'b0, den}) begin
            trial     = trial - {1'b0, den};
            r.part[0] = 1'b1;
         end
         r.rem = trial[GEO_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: hdl/c2s_div_pipe.sv
module c2s_div_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  c2s_pkg::lane_idx_type in_num,
   input  c2s_pkg::lane_geo_type den,
   output logic                  out_valid,
   input  logic                  out_ready,
   output c2s_pkg::lane_idx_type out_quot,
   output c2s_pkg::lane_geo_type out_rem
);

   localparam int LAST = c2s_pkg::DIV_STAGES - 1;

   c2s_pkg::div_state_type [c2s_pkg::NUM_LANES-1:0] st_ff [c2s_pkg::DIV_STAGES];
   c2s_pkg::div_state_type [c2s_pkg::NUM_LANES-1:0] st_in [c2s_pkg::DIV_STAGES];
   logic [c2s_pkg::DIV_STAGES-1:0] valid_ff;
   logic [c2s_pkg::DIV_STAGES-1:0] valid_in;
   logic [c2s_pkg::DIV_STAGES:0]   stage_ready;
   logic                           rem_ok;

   // a stage takes new data when empty or when its contents move on
   always_comb begin
      stage_ready[c2s_pkg::DIV_STAGES] = out_ready;
      for (int k = LAST; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   for (genvar k = 0; k < c2s_pkg::DIV_STAGES; k++) begin : g_stage
      logic                                            src_valid;
      c2s_pkg::div_state_type [c2s_pkg::NUM_LANES-1:0] src;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         for (genvar l = 0; l < c2s_pkg::NUM_LANES; l++) begin : g_lane
            assign src[l] = '{rem: '0, part: in_num[l]};
         end
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src       = st_ff[k-1];
      end

      assign valid_in[k] = stage_ready[k] ? src_valid : valid_ff[k];

      for (genvar l = 0; l < c2s_pkg::NUM_LANES; l++) begin : g_step
         assign st_in[k][l] = stage_ready[k] ? c2s_pkg::div_step(src[l], den[l]) :
                                               st_ff[k][l];
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      st_ff <= st_in;
   end

   // results of the last stage
   always_comb begin
      rem_ok = 1'b1;
      for (int l = 0; l < c2s_pkg::NUM_LANES; l++) begin
         out_quot[l] = st_ff[LAST][l].part;
         out_rem[l]  = st_ff[LAST][l].rem;
         if (st_ff[LAST][l].rem >= den[l]) begin
            rem_ok = 1'b0;
         end
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[LAST];

   a_enter: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff[0])
      else $error("accepted request did not enter first stage");

   a_rem: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> rem_ok)
      else $error("remainder not below divisor");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] && !stage_ready[0] |=> valid_ff[0] && $stable(st_ff[0]))
      else $error("stalled first stage changed");

endmodule

FILE: hdl/c2s_combine.sv
module c2s_combine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  c2s_pkg::lane_idx_type in_quot,
   input  c2s_pkg::lane_geo_type in_rem,
   input  c2s_pkg::dim_geo_type  ssz,
   output logic                  out_valid,
   input  logic                  out_ready,
   output c2s_pkg::idx_type      shard_number,
   output c2s_pkg::idx_type      slot_in_shard
);

   localparam int NST  = c2s_pkg::MAX_DIMS;
   localparam int LAST = NST - 1;

   c2s_pkg::idx_type     shard_ff [NST];
   c2s_pkg::idx_type     shard_in [NST];
   c2s_pkg::idx_type     slot_ff  [NST];
   c2s_pkg::idx_type     slot_in  [NST];
   c2s_pkg::dim_geo_type q_ff     [NST];
   c2s_pkg::dim_geo_type q_in     [NST];
   c2s_pkg::dim_geo_type r_ff     [NST];
   c2s_pkg::dim_geo_type r_in     [NST];
   c2s_pkg::dim_geo_type a_ff     [NST];
   c2s_pkg::dim_geo_type a_in     [NST];
   logic [NST-1:0]       valid_ff;
   logic [NST-1:0]       valid_in;
   logic [NST:0]         stage_ready;

   // one row-major step: acc * extent + coordinate, wrapping
   function automatic c2s_pkg::idx_type mac(c2s_pkg::idx_type acc, c2s_pkg::geo_type m,
                                            c2s_pkg::geo_type add);
      logic [c2s_pkg::IDX_W+c2s_pkg::GEO_W-1:0] p;
      p = acc * m + add;
      return p[c2s_pkg::IDX_W-1:0];
   endfunction

   // ready chain
   always_comb begin
      stage_ready[NST] = out_ready;
      for (int k = LAST; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   for (genvar k = 0; k < NST; k++) begin : g_stage
      if (k == 0) begin : g_first
         // slowest dimension seeds both sums
         assign valid_in[k] = stage_ready[k] ? in_valid : valid_ff[k];
         assign shard_in[k] = stage_ready[k] ? in_quot[0] : shard_ff[k];
         assign slot_in[k]  = stage_ready[k] ? c2s_pkg::idx_type'(in_rem[0]) : slot_ff[k];
         for (genvar d = 0; d < c2s_pkg::MAX_DIMS; d++) begin : g_dim
            assign q_in[k][d] = stage_ready[k] ? in_quot[d][c2s_pkg::GEO_W-1:0] : q_ff[k][d];
            assign r_in[k][d] = stage_ready[k] ? in_rem[d] : r_ff[k][d];
            assign a_in[k][d] = stage_ready[k] ?
                                in_quot[c2s_pkg::MAX_DIMS+d][c2s_pkg::GEO_W-1:0] : a_ff[k][d];
         end
      end else begin : g_next
         // fold in dimension k
         assign valid_in[k] = stage_ready[k] ? valid_ff[k-1] : valid_ff[k];
         assign shard_in[k] = stage_ready[k] ?
                              mac(shard_ff[k-1], a_ff[k-1][k], q_ff[k-1][k]) : shard_ff[k];
         assign slot_in[k]  = stage_ready[k] ?
                              mac(slot_ff[k-1], ssz[k], r_ff[k-1][k]) : slot_ff[k];
         assign q_in[k]     = stage_ready[k] ? q_ff[k-1] : q_ff[k];
         assign r_in[k]     = stage_ready[k] ? r_ff[k-1] : r_ff[k];
         assign a_in[k]     = stage_ready[k] ? a_ff[k-1] : a_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      shard_ff <= shard_in;
      slot_ff  <= slot_in;
      q_ff     <= q_in;
      r_ff     <= r_in;
      a_ff     <= a_in;
   end

   assign in_ready      = stage_ready[0];
   assign out_valid     = valid_ff[LAST];
   assign shard_number  = shard_ff[LAST];
   assign slot_in_shard = slot_ff[LAST];

endmodule

FILE: hdl/chunk_to_shard_index.sv
// channel    | handshake             | payload
// request    | req_valid / req_ready | req_linear_chunk[31:0]
// response   | rsp_valid / rsp_ready | rsp_shard_number[31:0], rsp_slot_in_shard[31:0]
// csr write  | csr_write_en          | csr_index[2:0], csr_wdata[31:0]
//
// one request per cycle while rsp_ready does not hold the pipeline back;
// the datapath is four chained index dividers, one shard-size divider and a
// multiply-accumulate stage per dimension
// synchronous active-high reset clears all valid bits and loads reset values into the csr registers
// every stage holds under stall and refills any empty stage, so bubbles close up
// csr writes take effect on the next cycle
module chunk_to_shard_index (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  c2s_pkg::idx_type      req_linear_chunk,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output c2s_pkg::idx_type      rsp_shard_number,
   output c2s_pkg::idx_type      rsp_slot_in_shard,
   input  logic                  csr_write_en,
   input  c2s_pkg::csr_idx_type  csr_index,
   input  c2s_pkg::csr_data_type csr_wdata
);

   localparam int NDIV = c2s_pkg::MAX_DIMS;
   localparam int LASTDIV = NDIV - 1;

   c2s_pkg::dims_type     dims_ff;
   c2s_pkg::dims_type     dims_in;
   c2s_pkg::csr_data_type geom_ff [c2s_pkg::MAX_DIMS];
   c2s_pkg::csr_data_type geom_in [c2s_pkg::MAX_DIMS];
   c2s_pkg::dcnt_type     n_eff;
   c2s_pkg::dim_geo_type  eff_cnt;
   c2s_pkg::dim_geo_type  eff_ssz;

   c2s_pkg::lane_idx_type dv_num  [NDIV];
   c2s_pkg::lane_geo_type dv_den  [NDIV];
   c2s_pkg::lane_idx_type dv_quot [NDIV];
   c2s_pkg::lane_geo_type dv_rem  [NDIV];
   logic [NDIV-1:0]       dv_in_valid;
   logic [NDIV-1:0]       dv_in_ready;
   logic [NDIV-1:0]       dv_out_valid;
   logic [NDIV-1:0]       dv_out_ready;
   logic                  cb_in_ready;

   // csr write decode
   always_comb begin
      dims_in = dims_ff;
      geom_in = geom_ff;
      if (csr_write_en) begin
         if (csr_index == c2s_pkg::CSR_DIMS_IN_USE) begin
            dims_in = csr_wdata[c2s_pkg::DIMS_W-1:0];
         end
         for (int d = 0; d < c2s_pkg::MAX_DIMS; d++) begin
            if (csr_index == c2s_pkg::csr_idx_type'(c2s_pkg::CSR_GEOM_BASE + d)) begin
               geom_in[d] = csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= c2s_pkg::DIMS_RESET;
         for (int d = 0; d < c2s_pkg::MAX_DIMS; d++) begin
            geom_ff[d] <= c2s_pkg::GEOM_RESET;
         end
      end else begin
         dims_ff <= dims_in;
         geom_ff <= geom_in;
      end
   end

   // effective dimension count, extents and shard sizes; unused dims and zero fields act as 1
   always_comb begin
      if (dims_ff < c2s_pkg::DIMS_W'(c2s_pkg::MIN_DIMS)) begin
         n_eff = c2s_pkg::dcnt_type'(c2s_pkg::MIN_DIMS);
      end else if (32'(dims_ff) > c2s_pkg::MAX_DIMS) begin
         n_eff = c2s_pkg::dcnt_type'(c2s_pkg::MAX_DIMS);
      end else begin
         n_eff = c2s_pkg::dcnt_type'(dims_ff);
      end
      for (int d = 0; d < c2s_pkg::MAX_DIMS; d++) begin
         eff_cnt[d] = c2s_pkg::GEO_ONE;
         eff_ssz[d] = c2s_pkg::GEO_ONE;
         if (32'(n_eff) > d) begin
            if (geom_ff[d][c2s_pkg::GEO_W-1:0] != '0) begin
               eff_cnt[d] = geom_ff[d][c2s_pkg::GEO_W-1:0];
            end
            if (geom_ff[d][2*c2s_pkg::GEO_W-1:c2s_pkg::GEO_W] != '0) begin
               eff_ssz[d] = geom_ff[d][2*c2s_pkg::GEO_W-1:c2s_pkg::GEO_W];
            end
         end
      end
   end

   for (genvar k = 0; k < NDIV; k++) begin : g_div
      if (k < LASTDIV) begin : g_coord
         // peel dimension MAX_DIMS-1-k off the running quotient in lane 0,
         // coordinates already found ride along in their own lanes
         localparam int D = c2s_pkg::MAX_DIMS - 1 - k;
         localparam int P = (k > 0) ? k - 1 : 0;
         always_comb begin
            for (int l = 0; l < c2s_pkg::NUM_LANES; l++) begin
               dv_num[k][l] = '0;
               dv_den[k][l] = c2s_pkg::GEO_ONE;
            end
            dv_den[k][0] = eff_cnt[D];
            if (k == 0) begin
               dv_num[k][0] = req_linear_chunk;
            end else begin
               dv_num[k][0]   = dv_quot[P][0];
               dv_num[k][D+1] = c2s_pkg::idx_type'(dv_rem[P][0]);
               for (int e = D + 2; e < c2s_pkg::MAX_DIMS; e++) begin
                  dv_num[k][e] = dv_quot[P][e];
               end
            end
         end
      end else begin : g_shard
         // coordinate over shard size per dimension, and shards per dimension
         always_comb begin
            logic [c2s_pkg::GEO_W:0] span;
            dv_num[k][0] = dv_quot[k-1][0];
            dv_num[k][1] = c2s_pkg::idx_type'(dv_rem[k-1][0]);
            for (int e = 2; e < c2s_pkg::MAX_DIMS; e++) begin
               dv_num[k][e] = dv_quot[k-1][e];
            end
            for (int d = 0; d < c2s_pkg::MAX_DIMS; d++) begin
               span = {1'b0, eff_cnt[d]} + {1'b0, eff_ssz[d]} - (c2s_pkg::GEO_W + 1)'(1);
               dv_num[k][c2s_pkg::MAX_DIMS+d] = c2s_pkg::idx_type'(span);
               dv_den[k][d]                   = eff_ssz[d];
               dv_den[k][c2s_pkg::MAX_DIMS+d] = eff_ssz[d];
            end
         end
      end

      if (k == 0) begin : g_in0
         assign dv_in_valid[k] = req_valid;
      end else begin : g_ink
         assign dv_in_valid[k]    = dv_out_valid[k-1];
         assign dv_out_ready[k-1] = dv_in_ready[k];
      end

      c2s_div_pipe u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_in_valid[k]),
         .in_ready  (dv_in_ready[k]),
         .in_num    (dv_num[k]),
         .den       (dv_den[k]),
         .out_valid (dv_out_valid[k]),
         .out_ready (dv_out_ready[k]),
         .out_quot  (dv_quot[k]),
         .out_rem   (dv_rem[k])
      );
   end

   assign dv_out_ready[LASTDIV] = cb_in_ready;
   assign req_ready             = dv_in_ready[0];

   // row-major sums of shard and in-shard coordinates
   c2s_combine u_combine (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (dv_out_valid[LASTDIV]),
      .in_ready      (cb_in_ready),
      .in_quot       (dv_quot[LASTDIV]),
      .in_rem        (dv_rem[LASTDIV]),
      .ssz           (eff_ssz),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .shard_number  (rsp_shard_number),
      .slot_in_shard (rsp_slot_in_shard)
   );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int LATENCY   = 45;
   localparam int WD_LIMIT  = 4000;
   localparam int N_PHASES  = 6;
   localparam int N_RANDOM  = 100;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   c2s_pkg::idx_type      req_linear_chunk = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   c2s_pkg::idx_type      rsp_shard_number;
   c2s_pkg::idx_type      rsp_slot_in_shard;
   logic                  csr_write_en = 1'b0;
   c2s_pkg::csr_idx_type  csr_index = '0;
   c2s_pkg::csr_data_type csr_wdata = '0;

   chunk_to_shard_index uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_linear_chunk(req_linear_chunk),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_shard_number(rsp_shard_number), .rsp_slot_in_shard(rsp_slot_in_shard),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   typedef struct packed {
      c2s_pkg::idx_type shard;
      c2s_pkg::idx_type slot;
   } shard_loc_type;

   // shadow copy of the registers
   c2s_pkg::dims_type     sh_dims;
   c2s_pkg::csr_data_type sh_geom [c2s_pkg::MAX_DIMS];

   c2s_pkg::idx_type pending_chunks [$];
   shard_loc_type    expected_locs [$];
   int               mismatches = 0;
   int               stall_cycles = 0;
   bit               calm = 1'b0;
   bit               done = 1'b0;
   bit               req_fired = 1'b0;
   int               req_gap = 0;
   int               rsp_gap = 0;

   function automatic longint unsigned dim_count(int d);
      longint unsigned c;
      c = {48'd0, sh_geom[d][15:0]};
      return (c == 64'd0) ? 64'd1 : c;
   endfunction

   function automatic longint unsigned dim_shard(int d);
      longint unsigned s;
      s = {48'd0, sh_geom[d][31:16]};
      return (s == 64'd0) ? 64'd1 : s;
   endfunction

   // map a linear chunk index to shard number and slot
   function automatic shard_loc_type locate_chunk(c2s_pkg::idx_type chunk);
      longint unsigned cs [c2s_pkg::MAX_DIMS];
      longint unsigned ss [c2s_pkg::MAX_DIMS];
      longint unsigned is [c2s_pkg::MAX_DIMS];
      longint unsigned co [c2s_pkg::MAX_DIMS];
      longint unsigned x, shard, slot, cnt, ssz;
      int n;
      shard_loc_type r;
      x = {32'd0, chunk};
      shard = 0;
      slot = 0;
      n = int'(sh_dims);
      if (n < c2s_pkg::MIN_DIMS) n = c2s_pkg::MIN_DIMS;
      if (n > c2s_pkg::MAX_DIMS) n = c2s_pkg::MAX_DIMS;
      cs[n-1] = 1;
      ss[n-1] = 1;
      is[n-1] = 1;
      for (int i = n - 1; i > 0; i--) begin
         cnt = dim_count(i);
         ssz = dim_shard(i);
         // saturating chunk stride
         if (cs[i] > 64'hFFFF_FFFF_FFFF_FFFF / cnt) cs[i-1] = 64'hFFFF_FFFF_FFFF_FFFF;
         else cs[i-1] = cs[i] * cnt;
         ss[i-1] = ss[i] * ((cnt + ssz - 1) / ssz);
         is[i-1] = is[i] * ssz;
      end
      co[0] = x / cs[0];
      for (int i = 1; i < n; i++) co[i] = (x % cs[i-1]) / cs[i];
      for (int i = 0; i < n; i++) begin
         ssz = dim_shard(i);
         shard += (co[i] / ssz) * ss[i];
         slot  += (co[i] % ssz) * is[i];
      end
      r.shard = shard[31:0];
      r.slot  = slot[31:0];
      return r;
   endfunction

   task automatic write_csr(int idx, logic [31:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= c2s_pkg::csr_idx_type'(idx);
      csr_wdata    <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx == c2s_pkg::CSR_DIMS_IN_USE) sh_dims = val[2:0];
      else if (idx >= c2s_pkg::CSR_GEOM_BASE &&
               idx < c2s_pkg::CSR_GEOM_BASE + c2s_pkg::MAX_DIMS)
         sh_geom[idx - c2s_pkg::CSR_GEOM_BASE] = val;
   endtask

   task automatic queue_chunk(c2s_pkg::idx_type c);
      pending_chunks = {pending_chunks, c};
      expected_locs  = {expected_locs, locate_chunk(c)};
   endtask

   function automatic logic [31:0] rand_geom(int style);
      logic [15:0] c, s;
      case (style)
         0: begin c = 16'($urandom_range(1, 6)); s = 16'($urandom_range(1, 4)); end
         1: begin c = 16'($urandom_range(0, 40)); s = 16'($urandom_range(0, 12)); end
         default: begin c = 16'($urandom); s = 16'($urandom); end
      endcase
      return {s, c};
   endfunction

   // random chunk index, mostly inside the grid
   function automatic c2s_pkg::idx_type rand_chunk();
      longint unsigned total;
      int n;
      n = int'(sh_dims);
      if (n < c2s_pkg::MIN_DIMS) n = c2s_pkg::MIN_DIMS;
      if (n > c2s_pkg::MAX_DIMS) n = c2s_pkg::MAX_DIMS;
      total = 1;
      for (int i = 0; i < n; i++) if (total < 64'h1_0000_0000) total *= dim_count(i);
      case ($urandom_range(0, 9))
         0: return c2s_pkg::idx_type'($urandom);
         1: return c2s_pkg::idx_type'('1);
         default: begin
            if (total > 64'h1_0000_0000) return c2s_pkg::idx_type'($urandom);
            return c2s_pkg::idx_type'({$urandom, $urandom} % (total + 2));
         end
      endcase
   endfunction

   task automatic wait_idle();
      while (expected_locs.size() != 0 || pending_chunks.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fired) begin
         // hold until accepted
      end else if (req_gap > 0) begin
         req_gap <= req_gap - 1;
         req_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
         req_gap <= $urandom_range(0, 13);
         req_valid <= 1'b0;
      end else if (pending_chunks.size() != 0) begin
         req_valid <= 1'b1;
         req_linear_chunk <= pending_chunks[0];
      end else begin
         req_valid <= 1'b0;
      end
   end

   // response backpressure
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_ready <= !reset;
         rsp_gap <= 0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_gap <= $urandom_range(0, 13);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // accept requests, check responses, watchdog
   always @(posedge clock) begin
      shard_loc_type e;
      req_fired <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (req_valid && req_ready) void'(pending_chunks.pop_front());
         if (rsp_valid && rsp_ready) begin
            if (expected_locs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %h %h",
                  rsp_shard_number, rsp_slot_in_shard);
            end else begin
               e = expected_locs.pop_front();
               if (e.shard !== rsp_shard_number || e.slot !== rsp_slot_in_shard) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected shard %0d slot %0d, got shard %0d slot %0d",
                        e.shard, e.slot, rsp_shard_number, rsp_slot_in_shard);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || done ||
             (pending_chunks.size() == 0 && expected_locs.size() == 0))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WD_LIMIT) begin
            $display("testbench failed");
            $finish;
         end
      end
   end

   initial begin
      sh_dims = c2s_pkg::DIMS_RESET;
      for (int d = 0; d < c2s_pkg::MAX_DIMS; d++) sh_geom[d] = c2s_pkg::GEOM_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset geometry, field extremes
      queue_chunk('0);
      queue_chunk(c2s_pkg::idx_type'(1));
      queue_chunk(c2s_pkg::idx_type'('1));
      queue_chunk(c2s_pkg::idx_type'(32'h8000_0000));
      wait_idle();

      // directed: small grid with uneven shards, zero fields, index past the grid
      write_csr(c2s_pkg::CSR_DIMS_IN_USE, 3);
      write_csr(c2s_pkg::CSR_GEOM_BASE + 0, {16'd2, 16'd5});
      write_csr(c2s_pkg::CSR_GEOM_BASE + 1, {16'd0, 16'd3});
      write_csr(c2s_pkg::CSR_GEOM_BASE + 2, {16'd3, 16'd0});
      for (int i = 0; i < 8; i++) queue_chunk(c2s_pkg::idx_type'(i * 7));
      queue_chunk(c2s_pkg::idx_type'(15));
      queue_chunk(c2s_pkg::idx_type'(1000));
      queue_chunk(c2s_pkg::idx_type'('1));
      wait_idle();

      // directed: dims out of range both ways, wide strides
      write_csr(c2s_pkg::CSR_DIMS_IN_USE, 7);
      for (int d = 0; d < c2s_pkg::MAX_DIMS; d++)
         write_csr(c2s_pkg::CSR_GEOM_BASE + d, 32'hFFFF_FFFF);
      queue_chunk('0);
      queue_chunk(c2s_pkg::idx_type'('1));
      queue_chunk(c2s_pkg::idx_type'(32'h1234_5678));
      wait_idle();
      write_csr(c2s_pkg::CSR_DIMS_IN_USE, 0);
      write_csr(c2s_pkg::CSR_GEOM_BASE + 1, 32'h0001_FFFF);
      queue_chunk(c2s_pkg::idx_type'('1));
      queue_chunk(c2s_pkg::idx_type'(32'h0001_0000));
      queue_chunk(c2s_pkg::idx_type'(32'h5555_AAAA));
      wait_idle();

      // random phases over several geometries
      for (int p = 0; p < N_PHASES; p++) begin
         write_csr(c2s_pkg::CSR_DIMS_IN_USE,
                   (p < 5) ? $urandom_range(3, 5) : $urandom_range(0, 7));
         for (int d = 0; d < c2s_pkg::MAX_DIMS; d++)
            write_csr(c2s_pkg::CSR_GEOM_BASE + d, rand_geom((p == 4) ? 2 : p % 2));
         if (p == N_PHASES - 1) calm = 1'b1;
         for (int i = 0; i < N_RANDOM; i++) queue_chunk(rand_chunk());
         wait_idle();
      end

      done = 1'b1;
      if (mismatches == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end

endmodule

FILE: files.f
hdl/c2s_pkg.sv
hdl/c2s_div_pipe.sv
hdl/c2s_combine.sv
hdl/chunk_to_shard_index.sv
verif/testbench.sv
